// ===== hw/rtl/activator_inhibitor_grid_automaton_macros.svh =====
// Assertion macros for the activator-inhibitor grid automaton.
`ifndef ACTIVATOR_INHIBITOR_GRID_AUTOMATON_MACROS_SVH
`define ACTIVATOR_INHIBITOR_GRID_AUTOMATON_MACROS_SVH

// same-cycle implication
`define AIGA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AIGA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/aiga_pkg.sv =====
// Package: sizes, request codes, controller states and command/status structs.
`timescale 1ns / 1ps
`default_nettype none
package aiga_pkg;
  localparam int GRID_SIZE = 128;
  localparam int ADDR_W    = $clog2(GRID_SIZE);
  localparam int WIN_W     = GRID_SIZE + 4;
  localparam int SW_W      = $clog2(WIN_W);
  localparam int LD_W      = $clog2(GRID_SIZE + 3);
  localparam int CLR_W     = ADDR_W + 1;

  localparam logic [7:0] WEIGHT_RESET = 8'd32;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_LOAD_RD,
    ST_LOAD_SH,
    ST_SWEEP,
    ST_ROW_WR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic win_clear;
    logic clr_wr;
    logic rd_cell;
    logic wr_cell;
    logic rd_load;
    logic win_shift;
    logic sweep;
    logic wr_gen;
    logic flip;
    logic post;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       load_more;
    logic       sweep_last;
    logic       gen_last;
    logic       out_free;
    logic [1:0] req_mode;
  } stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/aiga_ctrl.sv =====
// Controller: sequences clear pass, cell access and generation sweep.
`timescale 1ns / 1ps
`default_nettype none
module aiga_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     mode,
  output logic           in_stall,
  input  aiga_pkg::stat_t st,
  output aiga_pkg::cmd_t  cmd
);
  import aiga_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (st.clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_WRITE || mode == MODE_READ) state_next = ST_CELL_RD;
          else if (mode == MODE_STEP) state_next = ST_LOAD_RD;
          else state_next = ST_FINISH;
        end
      end
      ST_CELL_RD: state_next = (st.req_mode == MODE_WRITE) ? ST_CELL_WR : ST_FINISH;
      ST_CELL_WR: state_next = ST_FINISH;
      ST_LOAD_RD: state_next = ST_LOAD_SH;
      ST_LOAD_SH: state_next = st.load_more ? ST_LOAD_RD : ST_SWEEP;
      ST_SWEEP:   if (st.sweep_last) state_next = ST_ROW_WR;
      ST_ROW_WR:  state_next = st.gen_last ? ST_FINISH : ST_LOAD_RD;
      ST_FINISH:  if (st.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_CLEAR:   cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.capture   = in_valid;
        cmd.win_clear = in_valid && (mode == MODE_STEP);
      end
      ST_CELL_RD: cmd.rd_cell = 1'b1;
      ST_CELL_WR: cmd.wr_cell = 1'b1;
      ST_LOAD_RD: cmd.rd_load = 1'b1;
      ST_LOAD_SH: cmd.win_shift = 1'b1;
      ST_SWEEP:   cmd.sweep = 1'b1;
      ST_ROW_WR: begin
        cmd.wr_gen = 1'b1;
        cmd.flip   = st.gen_last;
      end
      ST_FINISH:  cmd.post = st.out_free;
      default:    cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/aiga_dp.sv =====
// Datapath: row memory for both grids, 5-row window, cell rule, result register.
`timescale 1ns / 1ps
`default_nettype none
module aiga_dp (
  input  logic            clk,
  input  logic            rst,
  input  aiga_pkg::cmd_t  cmd,
  output aiga_pkg::stat_t st,
  input  logic            cfg_write,
  input  logic [7:0]      cfg_data,
  input  logic [1:0]      mode,
  input  logic [6:0]      row,
  input  logic [6:0]      col,
  input  logic            cell_in,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            cell_out,
  output logic [1:0]      done_mode
);
  import aiga_pkg::*;

  logic [GRID_SIZE-1:0] mem [2*GRID_SIZE];
  logic [GRID_SIZE-1:0] rd_data;
  logic [GRID_SIZE-1:0] wr_data;
  logic [ADDR_W:0]      wr_addr;
  logic [ADDR_W:0]      rd_addr;
  logic                 wr_en;

  logic [7:0]        weight;
  logic              cur;
  logic [1:0]        req_mode;
  logic [ADDR_W-1:0] req_row;
  logic [ADDR_W-1:0] req_col;
  logic              req_cell;
  logic              req_in;
  logic [CLR_W-1:0]  clr_cnt;
  logic [LD_W-1:0]   ld_cnt;
  logic [SW_W-1:0]   sw_cnt;
  logic              rd_zero;
  logic [WIN_W-1:0]  win [5];
  logic [GRID_SIZE-1:0] row_out;
  logic [ADDR_W-1:0] gen_row;
  logic [3:0]        act;
  logic [4:0]        inh;
  logic [12:0]       lhs;
  logic [12:0]       rhs;
  logic              new_bit;

  assign gen_row = ADDR_W'(ld_cnt - LD_W'(3));

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WEIGHT_RESET;
    end else if (cfg_write) begin
      weight <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode <= mode;
      req_row  <= ADDR_W'(row);
      req_col  <= ADDR_W'(col);
      req_cell <= cell_in;
      req_in   <= (32'(row) < GRID_SIZE) && (32'(col) < GRID_SIZE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur     <= 1'b0;
      clr_cnt <= '0;
      ld_cnt  <= '0;
      sw_cnt  <= '0;
    end else begin
      if (cmd.flip) cur <= ~cur;
      if (cmd.clr_wr) clr_cnt <= clr_cnt + CLR_W'(1);
      if (cmd.win_clear) ld_cnt <= '0;
      else if (cmd.win_shift) ld_cnt <= ld_cnt + LD_W'(1);
      if (cmd.sweep) sw_cnt <= st.sweep_last ? '0 : sw_cnt + SW_W'(1);
    end
  end

  always_comb begin
    rd_addr = cmd.rd_load ? {cur, ld_cnt[ADDR_W-1:0]} : {cur, req_row};
    wr_en   = cmd.clr_wr || (cmd.wr_cell && req_in) || cmd.wr_gen;
    wr_data = '0;
    wr_addr = clr_cnt;
    if (cmd.wr_cell) begin
      wr_data = rd_data;
      wr_data[req_col] = req_cell;
      wr_addr = {cur, req_row};
    end else if (cmd.wr_gen) begin
      wr_data = row_out;
      wr_addr = {~cur, gen_row};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_cell || cmd.rd_load) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_load) rd_zero <= (ld_cnt >= LD_W'(GRID_SIZE));
  end

  // window row 2 is the row being computed; bit 2+dc is column c+dc
  always_ff @(posedge clk) begin
    if (cmd.win_clear) begin
      for (int i = 0; i < 5; i++) win[i] <= '0;
    end else if (cmd.win_shift) begin
      for (int i = 0; i < 4; i++) win[i] <= win[i+1];
      win[4] <= rd_zero ? '0 : {2'b00, rd_data, 2'b00};
    end else if (cmd.sweep) begin
      for (int i = 0; i < 5; i++) win[i] <= {win[i][0], win[i][WIN_W-1:1]};
    end
  end

  always_comb begin
    act = '0;
    inh = '0;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (r >= 1 && r <= 3 && c >= 1 && c <= 3) begin
          if (!(r == 2 && c == 2)) act = act + 4'(win[r][c]);
        end else begin
          inh = inh + 5'(win[r][c]);
        end
      end
    end
    lhs = 13'({act, 4'b0000});
    rhs = 13'(inh) * 13'(weight);
    if (lhs > rhs) new_bit = 1'b1;
    else if (lhs < rhs) new_bit = 1'b0;
    else new_bit = win[2][2];
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep && (32'(sw_cnt) < GRID_SIZE)) begin
      row_out <= {new_bit, row_out[GRID_SIZE-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.post) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      cell_out  <= (req_mode == MODE_READ) && req_in && rd_data[req_col];
      done_mode <= req_mode;
    end
  end

  always_comb begin
    st.clr_last   = (clr_cnt == CLR_W'(2*GRID_SIZE - 1));
    st.load_more  = (ld_cnt < LD_W'(2));
    st.sweep_last = (sw_cnt == SW_W'(WIN_W - 1));
    st.gen_last   = (ld_cnt == LD_W'(GRID_SIZE + 2));
    st.out_free   = !out_valid || !out_stall;
    st.req_mode   = req_mode;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/activator_inhibitor_grid_automaton.sv =====
// Top level of the activator-inhibitor grid automaton.
//  channel  | handshake           | payload
//  request  | in_valid / in_stall | mode, row, col, cell_in
//  result   | out_valid/out_stall | cell_out, done_mode
//  config   | cfg_write           | cfg_data (inhibitor weight, Q4.4)
// A write reads and rewrites its row, a read only reads it, unused mode 3 neither.
// A generation runs row by row: per row a row load (read, then shift),
// GRID_SIZE+4 window rotations, one row write.
// After reset a clear pass writes 2*GRID_SIZE rows with in_stall high.
// A stalled result holds the block in its final state; a new request is taken after.
`timescale 1ns / 1ps
`default_nettype none
`include "activator_inhibitor_grid_automaton_macros.svh"
module activator_inhibitor_grid_automaton (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [6:0] row,
  input  logic [6:0] col,
  input  logic       cell_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       cell_out,
  output logic [1:0] done_mode
);
  import aiga_pkg::*;

  cmd_t  cmd;
  stat_t st;

  aiga_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  aiga_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .row       (row),
    .col       (col),
    .cell_in   (cell_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cell_out  (cell_out),
    .done_mode (done_mode)
  );

  `AIGA_ASSERT_NOW(a_one_write, clk, rst, 1'b1, $onehot0({cmd.clr_wr, cmd.wr_cell, cmd.wr_gen}), "two memory writes in one cycle")
  `AIGA_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.post, !out_valid || !out_stall, "result register overwritten")
  `AIGA_ASSERT_NXT(a_busy_after_req, clk, rst, in_valid && !in_stall, in_stall, "request taken while busy")
  `AIGA_ASSERT_NOW(a_flip_on_write, clk, rst, cmd.flip, cmd.wr_gen, "buffer swap outside last row write")
endmodule
`default_nettype wire
